// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication whose consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/modexp_pkg.sv -----
package modexp_pkg;

    // operand width actually used by the arithmetic
    localparam int WIDTH   = 32;
    // width of each field on the stream ports
    localparam int FIELD_W = 32;
    localparam int CNT_W   = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] opnd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ----- hw/rtl/modexp_mulmod.sv -----
module modexp_mulmod (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  modexp_pkg::opnd_t      x,
    input  modexp_pkg::opnd_t      y,
    input  modexp_pkg::opnd_t      m,
    output modexp_pkg::opnd_t      product,
    output modexp_pkg::mm_status_t status
);

    modexp_pkg::opnd_t x_reg;
    modexp_pkg::opnd_t y_reg;
    modexp_pkg::opnd_t m_reg;
    modexp_pkg::opnd_t r_reg;
    modexp_pkg::opnd_t r_next;
    logic [modexp_pkg::CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    logic [modexp_pkg::WIDTH:0] dbl;
    logic [modexp_pkg::WIDTH:0] sum;
    logic [modexp_pkg::WIDTH:0] m_ext;
    modexp_pkg::opnd_t          fold;
    logic                       last;

    // one multiplier bit per cycle, msb first: r = (2r + bit*y) mod m
    // y < m (or y = 1) keeps every partial below 2m, so one subtract suffices
    always_comb begin
        m_ext = {1'b0, m_reg};
        dbl   = {r_reg, 1'b0};
        if (dbl >= m_ext) begin
            fold = modexp_pkg::WIDTH'(dbl - m_ext);
        end else begin
            fold = dbl[modexp_pkg::WIDTH-1:0];
        end
        sum = {1'b0, fold} + (x_reg[modexp_pkg::WIDTH-1] ? {1'b0, y_reg} : '0);
        if (sum >= m_ext) begin
            r_next = modexp_pkg::WIDTH'(sum - m_ext);
        end else begin
            r_next = sum[modexp_pkg::WIDTH-1:0];
        end
    end

    assign last = (cnt_reg == modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
            r_reg <= '0;
        end else if (busy_reg) begin
            x_reg <= x_reg << 1;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product     = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- hw/rtl/modular_exponentiation_unit.sv -----
// Computes base^exponent mod modulus by right-to-left square-and-multiply, one item at a
// time. All products go through a bit-serial modular multiplier that retires one bit of
// its multiplier operand per cycle, and that multiplier sets the pace. After the accepting
// cycle an item loads and reduces the base. Then, for every exponent bit up to the highest
// set one, it passes a control step, a multiply when the bit is set and a square (the square
// after the highest set bit is skipped), and finally hands the result to the output
// register. A zero modulus returns 0 with bad_modulus set, a zero exponent returns 1 (even
// for modulus 1); both go straight to the output stage. A new item is taken while the
// previous result still waits in the output register.
`include "assert_macros.svh"

module modular_exponentiation_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // base [31:0], exponent [63:32], modulus [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // power_mod [31:0]
    output logic        m_tuser    // bad_modulus [0]
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_SQR  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    modexp_pkg::opnd_t base_reg, base_next;
    modexp_pkg::opnd_t exp_reg, exp_next;
    modexp_pkg::opnd_t mod_reg, mod_next;
    modexp_pkg::opnd_t acc_reg, acc_next;
    logic bad_reg, bad_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [31:0] out_data_reg;
    logic out_bad_reg;

    logic                   mm_start;
    modexp_pkg::opnd_t      mm_x;
    modexp_pkg::opnd_t      mm_y;
    modexp_pkg::opnd_t      mm_product;
    modexp_pkg::mm_status_t mm_status;

    modexp_pkg::opnd_t in_base, in_exp, in_mod;
    logic in_xfer, out_load;
    logic in_zero_mod;
    logic mm_wait;

    assign in_base = s_tdata[modexp_pkg::WIDTH-1:0];
    assign in_exp  = s_tdata[modexp_pkg::FIELD_W +: modexp_pkg::WIDTH];
    assign in_mod  = s_tdata[2*modexp_pkg::FIELD_W +: modexp_pkg::WIDTH];
    assign in_zero_mod = (in_mod == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign mm_wait  = (state_reg == ST_RED) || (state_reg == ST_MUL) || (state_reg == ST_SQR);

    modexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .x       (mm_x),
        .y       (mm_y),
        .m       (mod_reg),
        .product (mm_product),
        .status  (mm_status)
    );

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        mm_start   = 1'b0;
        mm_x       = base_reg;
        mm_y       = base_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    base_next = in_base;
                    exp_next  = in_exp;
                    mod_next  = in_mod;
                    acc_next  = modexp_pkg::WIDTH'(1);
                    bad_next  = 1'b0;
                    if (in_zero_mod) begin
                        acc_next   = '0;
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (in_exp == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                // base * 1 mod m brings the base below the modulus
                mm_start   = 1'b1;
                mm_x       = base_reg;
                mm_y       = modexp_pkg::WIDTH'(1);
                state_next = ST_RED;
            end
            ST_RED: begin
                if (mm_status.done) begin
                    base_next  = mm_product;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (exp_reg == '0) begin
                    state_next = ST_DONE;
                end else if (exp_reg[0]) begin
                    mm_start   = 1'b1;
                    mm_x       = acc_reg;
                    mm_y       = base_reg;
                    state_next = ST_MUL;
                end else begin
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_status.done) begin
                    acc_next = mm_product;
                    if (exp_reg[modexp_pkg::WIDTH-1:1] == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        mm_start   = 1'b1;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mm_status.done) begin
                    base_next  = mm_product;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_STEP;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        bad_reg  <= bad_next;
        if (out_load) begin
            out_data_reg <= 32'(acc_reg);
            out_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

    `ASSERT_CLK(a_bad_gives_zero, !(m_tvalid && m_tuser) || (m_tdata == 32'd0), "bad data")
    `ASSERT_CLK(a_idle_mult_quiet, !s_tready || !mm_status.busy, "multiplier busy while idle")
    `ASSERT_CLK(a_done_in_wait, !mm_status.done || mm_wait, "multiplier done outside a wait")
    `ASSERT_NEXT(a_zero_mod, in_xfer && in_zero_mod, (state_reg == ST_DONE) && bad_reg, "no flag")

endmodule
